// File: rtl/point_in_polygon_test_unit_defines.svh
// ---------------------------------------------------------------------------
// Point-in-polygon test unit: assertion macros
// Shared property wrappers that use the clock and reset of the host module.
// ---------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pipt_pkg.sv
// ---------------------------------------------------------------------------
// Point-in-polygon test package
// Sizes, coordinate types and the edge request passed to the edge unit.
// ---------------------------------------------------------------------------
package pipt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 24;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int VIDX_W       = 6;
  localparam int CFG_W        = 7;
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // One edge from vertex i to vertex j, offered to the edge unit.
  typedef struct packed {
    logic    valid;
    vertex_t vi;
    vertex_t vj;
  } edge_req_t;

endpackage

// File: rtl/pipt_in_if.sv
// ---------------------------------------------------------------------------
// Point-in-polygon request channel
// Valid/ready channel carrying vertex loads and point queries.
// ---------------------------------------------------------------------------
interface pipt_in_if
  import pipt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              action;
  logic [VIDX_W-1:0] vertex_index;
  coord_t            coord_x;
  coord_t            coord_y;

  modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

// File: rtl/pipt_out_if.sv
// ---------------------------------------------------------------------------
// Point-in-polygon result channel
// Valid/ready channel carrying the inside flag of each query.
// ---------------------------------------------------------------------------
interface pipt_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

// File: rtl/pipt_cell.sv
// ---------------------------------------------------------------------------
// Point-in-polygon vertex cell
// Holds one vertex; loads it directly or takes its neighbor's on a shift.
// ---------------------------------------------------------------------------
module pipt_cell
  import pipt_pkg::*;
(
  input  logic    clk,
  input  logic    shift,
  input  logic    load,
  input  vertex_t load_v,
  input  vertex_t from_next,
  output vertex_t v
);

  vertex_t v_r;

  always_ff @(posedge clk) begin
    if (load) begin
      v_r <= load_v;
    end else if (shift) begin
      v_r <= from_next;
    end
  end

  assign v = v_r;

endmodule

// File: rtl/pipt_edge.sv
// ---------------------------------------------------------------------------
// Point-in-polygon edge unit
// Three-stage pipeline: differences, cross products, compare and toggle.
// ---------------------------------------------------------------------------
module pipt_edge
  import pipt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clear,
  input  edge_req_t req,
  input  coord_t    px,
  input  coord_t    py,
  output logic      busy,
  output logic      parity
);

  logic  s1_valid_r;
  logic  s1_up_r;
  diff_t s1_dpx_r, s1_dyji_r, s1_dxji_r, s1_dpy_r;
  logic  s2_valid_r;
  logic  s2_up_r;
  prod_t s2_l_r, s2_r_r;
  logic  parity_r;

  logic  straddle;
  logic  left;

  // The edge counts only when exactly one end lies above the point.
  assign straddle = (req.vi.y > py) != (req.vj.y > py);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req.valid && straddle;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dpx_r  <= DIFF_W'(px) - DIFF_W'(req.vi.x);
    s1_dyji_r <= DIFF_W'(req.vj.y) - DIFF_W'(req.vi.y);
    s1_dxji_r <= DIFF_W'(req.vj.x) - DIFF_W'(req.vi.x);
    s1_dpy_r  <= DIFF_W'(py) - DIFF_W'(req.vi.y);
    s1_up_r   <= req.vj.y > req.vi.y;
    s2_l_r    <= PROD_W'(s1_dpx_r) * PROD_W'(s1_dyji_r);
    s2_r_r    <= PROD_W'(s1_dxji_r) * PROD_W'(s1_dpy_r);
    s2_up_r   <= s1_up_r;
  end

  // Cross-multiplied form of px - xi < (xj - xi) * (py - yi) / (yj - yi).
  assign left = s2_up_r ? (s2_l_r < s2_r_r) : (s2_r_r < s2_l_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
    end else if (clear) begin
      parity_r <= 1'b0;
    end else if (s2_valid_r && left) begin
      parity_r <= !parity_r;
    end
  end

  assign busy   = s1_valid_r || s2_valid_r;
  assign parity = parity_r;

endmodule

// File: rtl/point_in_polygon_test_unit.sv
// ---------------------------------------------------------------------------
// Point-in-polygon test unit
// Even-odd ray-casting test over a rotating ring of vertex cells.
// ---------------------------------------------------------------------------
// Requests arrive on in_if: action 0 loads coord_x/coord_y into the cell at
// vertex_index, action 1 queries the point coord_x/coord_y. Each query gives
// one inside_res on out_if; loads give nothing. cfg_we writes vertex_count.
// A query rotates the whole ring of 64 cells once, one edge reaching the
// edge unit per cycle, then issues the closing edge and drains the
// three-stage edge pipeline. The unit returns to idle and can take the next
// request as the result enters the output register. The rotation is the
// same whatever vertex_count is.
// Reset clears the control state and vertex_count; vertex contents are not
// cleared and must be loaded before use. The output register holds a result
// while out_if.ready is low; a finished query waits for it to drain, and
// loads and a new query may still be accepted while a result waits.
// ---------------------------------------------------------------------------
`include "point_in_polygon_test_unit_defines.svh"

module point_in_polygon_test_unit
  import pipt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  pipt_in_if.sink          in_if,
  pipt_out_if.source       out_if,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ROTATE = 5'b00010,
    ST_FINAL  = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r;
  logic [CFG_W-1:0]   count_r;
  logic [CNT_W-1:0]   n_w;
  coord_t             px_r, py_r;
  vertex_t            prev_r, first_r, last_r;
  logic               out_valid_r, inside_r;
  logic               in_fire, query_fire, load_fire, out_free;
  logic               shift;
  logic [CNT_W-1:0]   cnt_ext;
  edge_req_t          edge_req;
  logic               eu_busy, eu_parity;
  vertex_t            cell_v [MAX_VERTICES];
  vertex_t            load_v;
  vertex_t            head;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign query_fire  = in_fire && (in_if.action == ACT_QUERY);
  assign load_fire   = in_fire && (in_if.action == ACT_LOAD);
  assign out_free    = !out_valid_r || out_if.ready;
  assign shift       = (state_r == ST_ROTATE);
  assign cnt_ext     = CNT_W'(cnt_r);
  assign head        = cell_v[0];
  assign load_v      = '{x: in_if.coord_x, y: in_if.coord_y};

  // Counts above the store size fall back to the store size.
  assign n_w = (32'(count_r) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // Ring of cells: each cell takes its upper neighbor, so cell 0 shows
  // vertex k after k shifts and a full turn restores the home order.
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    pipt_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .load      (load_fire && (int'(in_if.vertex_index) == k)),
      .load_v    (load_v),
      .from_next (cell_v[(k + 1) % MAX_VERTICES]),
      .v         (cell_v[k])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (query_fire) state_nxt = ST_ROTATE;
      ST_ROTATE: if (cnt_r == IDX_W'(MAX_VERTICES - 1)) state_nxt = ST_FINAL;
      ST_FINAL:  state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!eu_busy) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (query_fire) begin
        cnt_r <= '0;
      end else if (shift) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_fire) begin
      px_r <= in_if.coord_x;
      py_r <= in_if.coord_y;
    end
    if (shift) begin
      prev_r <= head;
      if (cnt_r == '0) begin
        first_r <= head;
      end
      if (cnt_ext + 1'b1 == n_w) begin
        last_r <= head;
      end
    end
  end

  // Edges (k, k-1) stream during the rotation; the wrap edge closes the walk.
  always_comb begin
    edge_req = '{valid: 1'b0, vi: head, vj: prev_r};
    if (state_r == ST_ROTATE) begin
      edge_req.valid = (cnt_r != '0) && (cnt_ext < n_w);
    end else if (state_r == ST_FINAL) begin
      edge_req.valid = (n_w != '0);
      edge_req.vi    = first_r;
      edge_req.vj    = last_r;
    end
  end

  pipt_edge u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (query_fire),
    .req    (edge_req),
    .px     (px_r),
    .py     (py_r),
    .busy   (eu_busy),
    .parity (eu_parity)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      inside_r <= eu_parity;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.inside_res = inside_r;

  `PIPT_ASSERT_NEXT(a_query_starts, query_fire, state_r == ST_ROTATE && cnt_r == '0, "query did not start a rotation")
  `PIPT_ASSERT_NEXT(a_rotate_steps, state_r == ST_ROTATE && cnt_r != IDX_W'(MAX_VERTICES - 1), state_r == ST_ROTATE && cnt_r == IDX_W'($past(cnt_r) + 1'b1), "rotation skipped a step")
  `PIPT_ASSERT_SAME(a_done_drained, state_r == ST_DONE, !eu_busy, "result taken before edge pipeline drained")
  `PIPT_ASSERT_SAME(a_edge_in_walk, edge_req.valid, state_r == ST_ROTATE || state_r == ST_FINAL, "edge issued outside a walk")

endmodule

// File: dv/pipt_result_checker.sv
// ---------------------------------------------------------------------------
// Point-in-polygon result checker
// Watches the request, result and register ports, keeps its own copy of the
// vertex store and vertex_count, predicts the inside flag of each query by
// even-odd edge crossing and compares every result against the oldest
// prediction.
// ---------------------------------------------------------------------------
module pipt_result_checker
  import pipt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  pipt_in_if               in_ch,
  pipt_out_if              out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int unsigned      mismatches,
  output int unsigned      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  coord_t           vx_mem [MAX_VERTICES];
  coord_t           vy_mem [MAX_VERTICES];
  logic [CFG_W-1:0] vertex_count;
  bit               inside_expected_q [$];
  int unsigned      err_count;

  // Even-odd crossing count. The crossing test is done exactly by cross
  // multiplication; the comparison flips when the edge runs downward.
  function automatic bit inside_by_parity(coord_t px, coord_t py);
    int     n;
    int     j;
    bit     parity;
    bit     left;
    coord_t xi, yi, xj, yj;
    diff_t  dxp, dye, dxe, dyp;
    prod_t  lhs, rhs;
    n = (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
    parity = 1'b0;
    for (int i = 0; i < n; i++) begin
      j  = (i == 0) ? n - 1 : i - 1;
      xi = vx_mem[i];
      yi = vy_mem[i];
      xj = vx_mem[j];
      yj = vy_mem[j];
      if ((yi > py) != (yj > py)) begin
        dxp = diff_t'(px) - diff_t'(xi);
        dye = diff_t'(yj) - diff_t'(yi);
        dxe = diff_t'(xj) - diff_t'(xi);
        dyp = diff_t'(py) - diff_t'(yi);
        lhs = prod_t'(dxp) * prod_t'(dye);
        rhs = prod_t'(dxe) * prod_t'(dyp);
        left = (yj > yi) ? (lhs < rhs) : (rhs < lhs);
        if (left) begin
          parity = ~parity;
        end
      end
    end
    return parity;
  endfunction

  always @(posedge clk) begin : monitor_proc
    bit want;
    bit predicted;
    if (!rst_n) begin
      vertex_count = '0;
      inside_expected_q.delete();
      err_count = 0;
    end else begin
      if (cfg_we) begin
        vertex_count = cfg_wdata;
      end
      // Results are matched before new queries are queued.
      if (out_ch.valid && out_ch.ready) begin
        if (inside_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual inside_res=%b",
                   $time, out_ch.inside_res);
          err_count++;
        end else begin
          want = inside_expected_q.pop_front();
          if (out_ch.inside_res !== want) begin
            $display("%0t: inside_res mismatch, expected %b, actual %b",
                     $time, want, out_ch.inside_res);
            err_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_LOAD) begin
          if (int'(in_ch.vertex_index) < MAX_VERTICES) begin
            vx_mem[in_ch.vertex_index] = in_ch.coord_x;
            vy_mem[in_ch.vertex_index] = in_ch.coord_y;
          end
        end else begin
          predicted = inside_by_parity(in_ch.coord_x, in_ch.coord_y);
          inside_expected_q = {inside_expected_q, predicted};
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= inside_expected_q.size();
  end

endmodule

// File: dv/tb.sv
// ---------------------------------------------------------------------------
// Point-in-polygon test unit testbench
// Loads polygons, sweeps vertex_count across its range and fires point
// queries with random idling on both channels; the result checker predicts
// and compares, and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb;
  import pipt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RANDOM_ITEMS = 600;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     STALL_LIMIT  = 3000;
  localparam int     LONG_HOLD    = 400;
  localparam int     UNIT         = 2560;
  localparam coord_t CMAX         = coord_t'((1 << (COORD_WIDTH - 1)) - 1);
  localparam coord_t CMIN         = coord_t'(-(1 << (COORD_WIDTH - 1)));

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      mismatches;
  int unsigned      outstanding;

  pipt_in_if  in_ch ();
  pipt_out_if out_ch ();

  point_in_polygon_test_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pipt_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Stimulus-side record of what was loaded, used to aim queries at the
  // polygon and to keep queries away from slots that were never written.
  bit          loaded   [MAX_VERTICES];
  coord_t      vx_seen  [MAX_VERTICES];
  coord_t      vy_seen  [MAX_VERTICES];
  int unsigned sent_items;
  int          calm_left;
  bit          calm_in;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coord_t coord_near(int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Leaves valid high after the handshake so that a following request can
  // go back to back; callers that pause lower it in the same step.
  task automatic send_request(logic act, logic [VIDX_W-1:0] idx, coord_t x, coord_t y);
    int gap;
    if (calm_left == 0) begin
      calm_left = $urandom_range(10, 40);
      calm_in   = ($urandom_range(0, 3) == 0);
    end
    calm_left--;
    gap = calm_in ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.vertex_index <= idx;
    in_ch.coord_x      <= x;
    in_ch.coord_y      <= y;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic load_vertex(int slot, coord_t x, coord_t y);
    vx_seen[slot] = x;
    vy_seen[slot] = y;
    loaded[slot]  = 1'b1;
    send_request(ACT_LOAD, VIDX_W'(slot), x, y);
  endtask

  task automatic query_point(coord_t x, coord_t y);
    send_request(ACT_QUERY, VIDX_W'($urandom), x, y);
  endtask

  // The register is written only once the unit has gone quiet.
  task automatic write_vertex_count(logic [CFG_W-1:0] value);
    int n;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    n = (int'(value) > MAX_VERTICES) ? MAX_VERTICES : int'(value);
    for (int k = 0; k < n; k++) begin
      if (!loaded[k]) begin
        load_vertex(k, coord_t'($urandom), coord_t'($urandom));
      end
    end
  endtask

  task automatic run_directed();
    // Axis-aligned square of side 5120 around the origin.
    load_vertex(0, coord_t'(-UNIT), coord_t'(-UNIT));
    load_vertex(1, coord_t'(UNIT), coord_t'(-UNIT));
    load_vertex(2, coord_t'(UNIT), coord_t'(UNIT));
    load_vertex(3, coord_t'(-UNIT), coord_t'(UNIT));
    // vertex_count is still zero after reset, so the origin is outside.
    query_point('0, '0);
    write_vertex_count(CFG_W'(4));
    query_point('0, '0);
    query_point(coord_t'(-UNIT), '0);
    query_point(coord_t'(UNIT), '0);
    query_point('0, coord_t'(UNIT));
    query_point('0, coord_t'(-UNIT));
    query_point(CMAX, CMAX);
    query_point(CMIN, CMIN);
    query_point(coord_t'(-UNIT), coord_t'(-UNIT));
    // Triangle spanning the full coordinate range stresses product widths.
    load_vertex(0, CMIN, CMIN);
    load_vertex(1, CMAX, CMIN);
    load_vertex(2, '0, CMAX);
    write_vertex_count(CFG_W'(3));
    query_point('0, '0);
    query_point(CMIN, '0);
    query_point(coord_t'(-1), coord_t'(CMIN + 1));
    query_point(CMAX, CMAX);
    // One and two vertex polygons are walked like any other.
    write_vertex_count(CFG_W'(1));
    query_point('0, '0);
    write_vertex_count(CFG_W'(2));
    query_point('0, '0);
    // Top slot, then a count above the store size.
    load_vertex(MAX_VERTICES - 1, CMAX, CMIN);
    write_vertex_count({CFG_W{1'b1}});
    query_point('0, '0);
    query_point(coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic random_phase();
    int               pick, n, span, a, b;
    logic [CFG_W-1:0] cnt;
    diff_t            sx, sy;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       cnt = CFG_W'(0);
      1:       cnt = CFG_W'(1);
      2:       cnt = CFG_W'(2);
      3:       cnt = CFG_W'(MAX_VERTICES);
      4:       cnt = CFG_W'($urandom_range(MAX_VERTICES + 1, 127));
      5:       cnt = CFG_W'($urandom_range(9, MAX_VERTICES - 1));
      default: cnt = CFG_W'($urandom_range(3, 8));
    endcase
    case ($urandom_range(0, 3))
      0:       span = 64;
      1:       span = 2048;
      2:       span = 65536;
      default: span = int'(CMAX);
    endcase
    write_vertex_count(cnt);
    n = (int'(cnt) > MAX_VERTICES) ? MAX_VERTICES : int'(cnt);
    for (int k = 0; k < n; k++) begin
      if (n <= 12 || $urandom_range(0, 7) == 0) begin
        load_vertex(k, coord_near(span), coord_near(span));
      end
    end
    repeat ($urandom_range(4, 14)) begin
      pick = $urandom_range(0, 9);
      if (n == 0 && pick >= 4 && pick <= 6) begin
        pick = 0;
      end
      case (pick)
        4: begin
          a = $urandom_range(0, n - 1);
          query_point(coord_near(span), vy_seen[a]);
        end
        5: begin
          a = $urandom_range(0, n - 1);
          query_point(vx_seen[a], vy_seen[a]);
        end
        6: begin
          // Midpoint of an edge lands on the crossing whenever it is exact.
          a  = $urandom_range(0, n - 1);
          b  = (a == 0) ? n - 1 : a - 1;
          sx = diff_t'(vx_seen[a]) + diff_t'(vx_seen[b]);
          sy = diff_t'(vy_seen[a]) + diff_t'(vy_seen[b]);
          query_point(coord_t'(sx >>> 1), coord_t'(sy >>> 1));
        end
        7: query_point(coord_t'($urandom), coord_t'($urandom));
        8: load_vertex($urandom_range(0, MAX_VERTICES - 1), coord_t'($urandom),
                       coord_t'($urandom));
        9: begin
          if (n > 0) begin
            load_vertex($urandom_range(0, n - 1), coord_near(span), coord_near(span));
          end else begin
            load_vertex($urandom_range(0, MAX_VERTICES - 1), coord_near(span),
                        coord_near(span));
          end
        end
        default: query_point(coord_near(span), coord_near(span));
      endcase
    end
  endtask

  // Result side: random hold-off after each result, calm stretches, and two
  // long stalls that back the unit up into its request port.
  initial begin : result_sink
    int gap, taken, quiet_left;
    bit quiet;
    taken      = 0;
    quiet_left = 0;
    quiet      = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        taken++;
        if (quiet_left == 0) begin
          quiet_left = $urandom_range(10, 40);
          quiet      = ($urandom_range(0, 3) == 0);
        end
        quiet_left--;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (taken == 15 || taken == 200) begin
          gap = LONG_HOLD;
        end
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_start;
    sent_items         = 0;
    calm_left          = 0;
    calm_in            = 1'b0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_LOAD;
    in_ch.vertex_index <= '0;
    in_ch.coord_x      <= '0;
    in_ch.coord_y      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      random_phase();
    end
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
